// ----- design/cdfc_pkg.sv -----
// Shared types, constants and segment tables for the clock display frame composer.
`timescale 1ns / 1ps

package cdfc_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [15:0] UNIT_LO    = 16'h4000;
	localparam logic [15:0] UNIT_HI    = 16'h8000;
	localparam logic [15:0] COLON_MARK = 16'h0020;
	localparam logic [15:0] PH2_BASE   = 16'h0038;
	localparam logic [15:0] SIGN_MARK  = 16'h0002;
	localparam logic [15:0] HUND_MARK  = 16'h0005;
	localparam logic [2:0]  MAX_ON     = 3'd5;

	typedef enum logic [1:0] {
		PH_HOURS   = 2'd0,
		PH_MINUTES = 2'd1,
		PH_MARKS   = 2'd2
	} phase_t;

	// one update as stored between front and back
	typedef struct packed {
		logic [31:0] w0;
		logic [31:0] w1;
		logic [15:0] w2r;
		logic        chg;
	} update_t;

	typedef struct packed {
		logic    valid;
		update_t data;
	} push_t;

	function automatic logic [15:0] tens_seg(input logic [3:0] d);
		logic [15:0] s;
		unique case (d)
			4'd0: s = 16'h003f;
			4'd1: s = 16'h0006;
			4'd2: s = 16'h005b;
			4'd3: s = 16'h004f;
			4'd4: s = 16'h0066;
			4'd5: s = 16'h006d;
			4'd6: s = 16'h007d;
			4'd7: s = 16'h0007;
			4'd8: s = 16'h007f;
			4'd9: s = 16'h006f;
			default: s = 16'h0000;
		endcase
		return s;
	endfunction

	function automatic logic [15:0] ones_seg(input logic [3:0] d);
		logic [15:0] s;
		unique case (d)
			4'd0: s = 16'h1f80;
			4'd1: s = 16'h0300;
			4'd2: s = 16'h2d80;
			4'd3: s = 16'h2780;
			4'd4: s = 16'h3300;
			4'd5: s = 16'h3680;
			4'd6: s = 16'h3e80;
			4'd7: s = 16'h0380;
			4'd8: s = 16'h3f80;
			4'd9: s = 16'h3780;
			default: s = 16'h0000;
		endcase
		return s;
	endfunction

	// hours tens digit: blank for 0 and for 3 and up
	function automatic logic [15:0] hour_tens_seg(input logic [3:0] d);
		logic [15:0] s;
		unique case (d)
			4'd1: s = 16'h0006;
			4'd2: s = 16'h005b;
			default: s = 16'h0000;
		endcase
		return s;
	endfunction

	// tens and ones of v; exact for v up to 99 (x*205 >> 11 == x/10)
	function automatic logic [7:0] split_dec(input logic [6:0] v);
		logic [14:0] p;
		logic [3:0]  t;
		logic [6:0]  r;
		p = 15'(v) * 15'd205;
		t = p[14:11];
		r = v - 7'(t) * 7'd10;
		return {t, r[3:0]};
	endfunction

	function automatic logic [15:0] pair_seg(input logic [6:0] v);
		logic [7:0] d;
		d = split_dec(v);
		return tens_seg(d[7:4]) + ones_seg(d[3:0]);
	endfunction

	function automatic logic [15:0] hour_seg(input logic [6:0] v);
		logic [7:0] d;
		d = split_dec(v);
		return hour_tens_seg(d[7:4]) + ones_seg(d[3:0]);
	endfunction

endpackage

// ----- design/clock_display_frame_composer.sv -----
// Top level of the clock display frame composer: config register, credit check, front, queue, back.
`timescale 1ns / 1ps

// An update is taken at a clock edge where start is high and busy is low. Its three frames
// (phase 0, 1, 2) come out on consecutive cycles, each marked by strobe for one cycle; with
// nothing ahead of it, phase 0 reaches the ports through the front stages, the queue and the
// sequencer's item register. last marks the third frame, and charge_led is valid only there.
// The receiver cannot stall: frames are shown once and must be taken as they come.
// The frame sequencer gives one frame per cycle while it holds an update, taking the next on
// its marks frame; busy rises when front pipeline and queue together hold DEPTH updates.
// dim_ticks is written through cfg_we/cfg_data and should be changed only while no update is
// in flight; on_ticks follows it directly.
module clock_display_frame_composer #(
	parameter int unsigned DEPTH = cdfc_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_data,
	input  logic              start,
	output logic              busy,
	input  logic [7:0]        hours,
	input  logic [7:0]        minutes,
	input  logic signed [7:0] temperature,
	input  logic [6:0]        humidity,
	input  logic              colon_on,
	input  logic              twelve_hour,
	input  logic              after_noon,
	input  logic              show_celsius,
	input  logic              alarm_weekdays,
	input  logic              alarm_one,
	input  logic              alarm_two,
	input  logic              charging,
	output logic              strobe,
	output logic [1:0]        phase,
	output logic [31:0]       frame,
	output logic [2:0]        on_ticks,
	output logic              charge_led,
	output logic              last
);
	import cdfc_pkg::*;

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned IW = $clog2(DEPTH + 4);

	logic [2:0]    dim_ticks_q;
	logic          accept;
	push_t         push;
	logic [1:0]    occupancy;
	update_t       head;
	logic          empty;
	logic          pop;
	logic [CW-1:0] count;
	logic [IW-1:0] inflight;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_ticks_q <= 3'd0;
		end else if (cfg_we) begin
			dim_ticks_q <= cfg_data;
		end
	end

	assign on_ticks = (dim_ticks_q > MAX_ON) ? 3'd0 : MAX_ON - dim_ticks_q;

	// front pipeline never stalls, so every word in it holds a queue slot
	assign inflight = IW'(occupancy) + IW'(count);
	assign busy     = (inflight >= IW'(DEPTH));
	assign accept   = start && !busy;

	cdfc_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.hours          (hours),
		.minutes        (minutes),
		.temperature    (temperature),
		.humidity       (humidity),
		.colon_on       (colon_on),
		.twelve_hour    (twelve_hour),
		.after_noon     (after_noon),
		.show_celsius   (show_celsius),
		.alarm_weekdays (alarm_weekdays),
		.alarm_one      (alarm_one),
		.alarm_two      (alarm_two),
		.charging       (charging),
		.push           (push),
		.occupancy      (occupancy)
	);

	cdfc_queue #(
		.DEPTH (DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.empty  (empty),
		.count  (count)
	);

	cdfc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.empty      (empty),
		.pop        (pop),
		.strobe     (strobe),
		.phase      (phase),
		.frame      (frame),
		.charge_led (charge_led),
		.last       (last)
	);

endmodule

// ----- design/cdfc_front.sv -----
// Front pipeline: takes an update and builds its three segment words over three stages.
`timescale 1ns / 1ps

module cdfc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [7:0]         hours,
	input  logic [7:0]         minutes,
	input  logic signed [7:0]  temperature,
	input  logic [6:0]         humidity,
	input  logic               colon_on,
	input  logic               twelve_hour,
	input  logic               after_noon,
	input  logic               show_celsius,
	input  logic               alarm_weekdays,
	input  logic               alarm_one,
	input  logic               alarm_two,
	input  logic               charging,
	output cdfc_pkg::push_t    push,
	output logic [1:0]         occupancy
);
	import cdfc_pkg::*;

	// stage 1 inputs
	logic signed [7:0]  t_sat;
	logic signed [10:0] t_sel;
	logic [6:0]         hum_sat;
	logic [15:0]        r0, l0, l1;

	logic               v_s1, v_s2, v_s3;
	logic [31:0]        w0_s1, w0_s2, w0_s3;
	logic [15:0]        w1l_s1, w1l_s2;
	logic signed [10:0] t_s1;
	logic               cel_s1, cel_s2;
	logic               chg_s1, chg_s2, chg_s3;
	logic signed [8:0]  st_s2;
	logic [31:0]        w1_s3;
	logic [15:0]        w2r_s3;

	// stage 2 logic
	logic signed [10:0] t_neg;
	logic [9:0]         mag9;
	logic [17:0]        prod;
	logic [7:0]         quo;
	logic signed [8:0]  fq;
	logic signed [8:0]  st_d;

	// stage 3 logic
	logic signed [8:0]  st_neg;
	logic               neg;
	logic [7:0]         mag;
	logic               hund;
	logic [7:0]         m2;
	logic [15:0]        r1, w2r_d;

	function automatic logic signed [8:0] cel_s2_sel(input logic cel,
		input logic signed [10:0] t, input logic signed [8:0] q);
		return cel ? t[8:0] : q + 9'sd32;
	endfunction

	always_comb begin
		hum_sat = (humidity > 7'd99) ? 7'd99 : humidity;
		r0 = pair_seg(hum_sat) + UNIT_LO + (alarm_weekdays ? UNIT_HI : 16'h0000);

		l0 = twelve_hour ? (after_noon ? UNIT_HI : UNIT_LO) : 16'h0000;
		if (colon_on) begin
			l0 = l0 + COLON_MARK;
		end
		if (hours <= 8'd99) begin
			l0 = l0 + hour_seg(hours[6:0]);
		end

		l1 = (minutes <= 8'd99) ? pair_seg(minutes[6:0]) : 16'h0000;
		if (alarm_one) begin
			l1 = l1 + UNIT_LO;
		end
		if (alarm_two) begin
			l1 = l1 + UNIT_HI;
		end

		if (temperature < -8'sd40) begin
			t_sat = -8'sd40;
		end else if (temperature > 8'sd85) begin
			t_sat = 8'sd85;
		end else begin
			t_sat = temperature;
		end
		// Fahrenheit path carries t*9, divided by 5 in the next stage
		t_sel = show_celsius ? 11'(t_sat) : (11'(t_sat) <<< 3) + 11'(t_sat);
	end

	always_comb begin
		t_neg = -t_s1;
		mag9  = t_s1[10] ? t_neg[9:0] : t_s1[9:0];
		prod  = 18'(mag9) * 18'd205;
		quo   = prod[17:10];
		// truncate toward zero: divide the magnitude, then restore the sign
		fq    = t_s1[10] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
		st_d  = cel_s2_sel(cel_s1, t_s1, fq);
	end

	always_comb begin
		st_neg = -st_s2;
		neg    = st_s2[8];
		mag    = neg ? st_neg[7:0] : st_s2[7:0];
		hund   = mag > 8'd99;
		m2     = hund ? mag - 8'd100 : mag;
		if (m2 > 8'd99) begin
			m2 = 8'd99;
		end
		r1    = pair_seg(m2[6:0]) + (cel_s2 ? UNIT_LO : UNIT_HI);
		w2r_d = PH2_BASE + (neg ? SIGN_MARK : 16'h0000) + (hund ? HUND_MARK : 16'h0000);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			w0_s1  <= {r0, l0};
			w1l_s1 <= l1;
			t_s1   <= t_sel;
			cel_s1 <= show_celsius;
			chg_s1 <= charging;
		end
		if (v_s1) begin
			w0_s2  <= w0_s1;
			w1l_s2 <= w1l_s1;
			st_s2  <= st_d;
			cel_s2 <= cel_s1;
			chg_s2 <= chg_s1;
		end
		if (v_s2) begin
			w0_s3  <= w0_s2;
			w1_s3  <= {r1, w1l_s2};
			w2r_s3 <= w2r_d;
			chg_s3 <= chg_s2;
		end
	end

	assign push.valid    = v_s3;
	assign push.data.w0  = w0_s3;
	assign push.data.w1  = w1_s3;
	assign push.data.w2r = w2r_s3;
	assign push.data.chg = chg_s3;

	assign occupancy = {1'b0, v_s1} + {1'b0, v_s2} + {1'b0, v_s3};

endmodule

// ----- design/cdfc_queue.sv -----
// Small word queue between the front pipeline and the frame sequencer.
`timescale 1ns / 1ps

module cdfc_queue #(
	parameter int unsigned DEPTH = cdfc_pkg::QUEUE_DEPTH,
	localparam int unsigned CW = $clog2(DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cdfc_pkg::push_t   push,
	input  logic              pop,
	output cdfc_pkg::update_t head,
	output logic              empty,
	output logic [CW-1:0]     count
);
	import cdfc_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	update_t       mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push.valid && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push.valid) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	assign head  = mem_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign count = count_q;

`ifndef ASSERT_OFF
	// credit check upstream must keep a full queue from taking a word
	assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> (count_q != CW'(DEPTH) || pop))
		else $error("queue written while full");

	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("queue read while empty");
`endif

endmodule

// ----- design/cdfc_back.sv -----
// Frame sequencer: plays each queued update out as three frames on consecutive cycles.
`timescale 1ns / 1ps

module cdfc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  cdfc_pkg::update_t head,
	input  logic              empty,
	output logic              pop,
	output logic              strobe,
	output logic [1:0]        phase,
	output logic [31:0]       frame,
	output logic              charge_led,
	output logic              last
);
	import cdfc_pkg::*;

	update_t item_q;
	phase_t  phase_q, phase_d;
	logic    active_q, active_d;

	always_comb begin
		// next update loads in the cycle after the marks frame, no gap
		pop      = !empty && (!active_q || phase_q == PH_MARKS);
		phase_d  = phase_q;
		active_d = active_q;
		if (pop) begin
			phase_d  = PH_HOURS;
			active_d = 1'b1;
		end else if (active_q) begin
			unique case (phase_q)
				PH_HOURS:   phase_d = PH_MINUTES;
				PH_MINUTES: phase_d = PH_MARKS;
				default: begin
					phase_d  = PH_HOURS;
					active_d = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HOURS;
			active_q <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			active_q <= active_d;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= head;
		end
	end

	always_comb begin
		unique case (phase_q)
			PH_HOURS:   frame = item_q.w0;
			PH_MINUTES: frame = item_q.w1;
			PH_MARKS:   frame = {item_q.w2r, 16'h0000};
			default:    frame = 32'h0000_0000;
		endcase
	end

	assign strobe     = active_q;
	assign phase      = phase_q;
	assign last       = active_q && (phase_q == PH_MARKS);
	assign charge_led = last && item_q.chg;

`ifndef ASSERT_OFF
	assert property (@(posedge clk) disable iff (!arst_n)
		(active_q && phase_q == PH_HOURS) |=> (active_q && phase_q == PH_MINUTES))
		else $error("hours frame not followed by minutes frame");

	assert property (@(posedge clk) disable iff (!arst_n)
		(active_q && phase_q == PH_MINUTES) |=> (active_q && phase_q == PH_MARKS))
		else $error("minutes frame not followed by marks frame");
`endif

endmodule
